/* hw/rtl/sdat_pkg.sv */
// Shared types and constants for the sorted daily alarm table.
// Depends on nothing; imported by sdat_ram users and the core.
package sdat_pkg;

  localparam int MIN_W      = 11;
  localparam int KIND_W     = 16;
  localparam int AMOUNT_W   = 32;
  localparam int POS_W      = 4;
  localparam int USED_W     = 5;
  localparam int WARN_SPAN  = 2 * 60;
  localparam int DAY_MIN    = 24 * 60;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_EVAL,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    logic [MIN_W-1:0]    alarm;
    logic [MIN_W-1:0]    start_min;
    logic [MIN_W-1:0]    end_min;
    logic [KIND_W-1:0]   kind;
    logic [AMOUNT_W-1:0] amount;
  } entry_t;

  // End of warning window: alarm plus span, wrapped once past a day.
  function automatic logic [MIN_W-1:0] end_minute(input logic [MIN_W-1:0] am);
    logic [MIN_W:0] sum;
    logic [MIN_W:0] wrapped;
    sum     = {1'b0, am} + (MIN_W + 1)'(WARN_SPAN);
    wrapped = sum - (MIN_W + 1)'(DAY_MIN);
    if (sum > (MIN_W + 1)'(DAY_MIN)) begin
      return wrapped[MIN_W-1:0];
    end
    return sum[MIN_W-1:0];
  endfunction

endpackage

/* hw/rtl/sdat_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/sorted_daily_alarm_table_core.sv */
// Top level of the sorted daily alarm table.
// Uses sdat_pkg and one sdat_ram instance for the entry store.

// The block keeps up to MAX_ALARMS daily alarms in ascending order of alarm
// minute and accepts one command beat when start is high and busy is low:
// insert (placed after every equal or earlier alarm), delete by position
// (gap closed), or query for the next alarm after now_minute. Every command
// produces exactly one result beat, shown for one cycle with out_valid high;
// the receiver cannot stall it, so capture it on that cycle. All entries sit
// in one RAM with a registered read port and one write port, and a single
// compare unit walks them, one entry per READ and EVAL pass: an insert moves
// the entries above its slot up one place from the top down, a delete moves
// the entries above the position down one place, and a query scans from the
// bottom until an alarm is later than now. Rejected commands and unknown ops
// skip the walk and go straight to the result beat. busy stays high until
// the cycle after the result beat. No clearing pass is needed after reset:
// data read from entries at or above the fill count is never used.
module sorted_daily_alarm_table_core
  import sdat_pkg::*;
#(
  parameter int MAX_ALARMS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [10:0]       in_alarm_minute,
  input  logic [10:0]       in_start_minute,
  input  logic [15:0]       in_event_kind,
  input  logic [31:0]       in_amount_bits,
  input  logic [3:0]        in_position,
  input  logic [10:0]       in_now_minute,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [10:0]       out_next_minute,
  output logic              out_next_day,
  output logic [4:0]        out_entries_used
);

  localparam int IDX_W = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
  localparam int CNT_W = $clog2(MAX_ALARMS + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int ENT_W = $bits(entry_t);

  // Sequencer and datapath registers
  fsm_t              state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [MIN_W-1:0]  key_r, key_nxt;       // insert minute or now minute
  entry_t            new_r, new_nxt;       // entry being inserted
  logic [CNT_W-1:0]  cur_r, cur_nxt;       // walk cursor
  logic [CNT_W-1:0]  count_r, count_nxt;   // fill count
  status_t           status_r, status_nxt;
  logic [MIN_W-1:0]  minute_r, minute_nxt;
  logic              day_r, day_nxt;
  logic [MIN_W-1:0]  first_r, first_nxt;   // alarm of entry 0 seen by a query

  // RAM port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;
  entry_t            rd_entry;

  logic              accept;
  op_t               in_op_e;
  logic              full, pos_bad, empty;
  logic              quick_done;
  logic              walk_end;
  logic              later;                // the shared compare unit
  logic [CNT_W-1:0]  cur_m1;
  logic [CMP_W-1:0]  pos_ext;

  sdat_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ALARMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign in_op_e  = op_t'(in_op);
  assign accept   = start && !busy;
  assign pos_ext  = CMP_W'(in_position);
  assign full     = (count_r == CNT_W'(MAX_ALARMS));
  assign pos_bad  = (pos_ext >= CMP_W'(count_r));
  assign empty    = (count_r == '0);
  assign cur_m1   = cur_r - 1'b1;
  assign later    = (rd_entry.alarm > key_r);

  // Commands that finish without touching the store
  always_comb begin
    case (in_op_e)
      OP_INSERT: quick_done = full;
      OP_DELETE: quick_done = pos_bad;
      OP_QUERY:  quick_done = empty;
      default:   quick_done = 1'b1;
    endcase
  end

  // Insert walks down to zero; delete and query walk up to the fill count
  assign walk_end = (op_r == OP_INSERT) ? (cur_r == '0) : (cur_r == count_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          state_nxt = quick_done ? FSM_DONE : FSM_READ;
        end
      end
      FSM_READ: begin
        state_nxt = walk_end ? FSM_DONE : FSM_EVAL;
      end
      FSM_EVAL: begin
        case (op_r)
          OP_INSERT: state_nxt = later ? FSM_READ : FSM_DONE;
          OP_DELETE: state_nxt = FSM_READ;
          OP_QUERY:  state_nxt = later ? FSM_DONE : FSM_READ;
          default:   state_nxt = FSM_DONE;
        endcase
      end
      FSM_DONE: state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    op_nxt     = op_r;
    key_nxt    = key_r;
    new_nxt    = new_r;
    cur_nxt    = cur_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    minute_nxt = minute_r;
    day_nxt    = day_r;
    first_nxt  = first_r;
    ram_we     = 1'b0;
    ram_waddr  = cur_r[IDX_W-1:0];
    ram_wdata  = new_r;
    ram_raddr  = cur_r[IDX_W-1:0];
    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          op_nxt            = in_op_e;
          key_nxt           = (in_op_e == OP_INSERT) ? in_alarm_minute : in_now_minute;
          new_nxt.alarm     = in_alarm_minute;
          new_nxt.start_min = in_start_minute;
          new_nxt.end_min   = end_minute(in_alarm_minute);
          new_nxt.kind      = in_event_kind;
          new_nxt.amount    = in_amount_bits;
          minute_nxt        = '0;
          day_nxt           = 1'b0;
          status_nxt        = STATUS_OK;
          case (in_op_e)
            OP_INSERT: begin
              cur_nxt = count_r;
              if (full) status_nxt = STATUS_FULL;
            end
            OP_DELETE: begin
              cur_nxt = CNT_W'(pos_ext + 1'b1);
              if (pos_bad) status_nxt = STATUS_RANGE;
            end
            OP_QUERY: begin
              cur_nxt = '0;
              if (empty) status_nxt = STATUS_EMPTY;
            end
            default: cur_nxt = '0;
          endcase
        end
      end
      FSM_READ: begin
        case (op_r)
          OP_INSERT: begin
            ram_raddr = cur_m1[IDX_W-1:0];
            if (walk_end) begin
              // slot zero: every stored alarm was later
              ram_we    = 1'b1;
              ram_waddr = '0;
              count_nxt = count_r + 1'b1;
            end
          end
          OP_DELETE: begin
            if (walk_end) count_nxt = count_r - 1'b1;
          end
          OP_QUERY: begin
            if (walk_end) begin
              // wrap to tomorrow's first alarm
              minute_nxt = first_r;
              day_nxt    = 1'b1;
            end
          end
          default: ;
        endcase
      end
      FSM_EVAL: begin
        case (op_r)
          OP_INSERT: begin
            ram_we = 1'b1;
            if (later) begin
              // shift this entry up one place and keep walking down
              ram_wdata = rd_entry;
              cur_nxt   = cur_m1;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end
          OP_DELETE: begin
            ram_we    = 1'b1;
            ram_waddr = cur_m1[IDX_W-1:0];
            ram_wdata = rd_entry;
            cur_nxt   = cur_r + 1'b1;
          end
          OP_QUERY: begin
            if (cur_r == '0) first_nxt = rd_entry.alarm;
            if (later) begin
              minute_nxt = rd_entry.alarm;
            end else begin
              cur_nxt = cur_r + 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FSM_IDLE;
      count_r  <= '0;
      op_r     <= OP_NOP;
      cur_r    <= '0;
      status_r <= STATUS_OK;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      op_r     <= op_nxt;
      cur_r    <= cur_nxt;
      status_r <= status_nxt;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    new_r    <= new_nxt;
    minute_r <= minute_nxt;
    day_r    <= day_nxt;
    first_r  <= first_nxt;
  end

  // Result beat is shown during the done cycle only
  assign busy             = (state_r != FSM_IDLE);
  assign out_valid        = (state_r == FSM_DONE);
  assign out_status       = status_r;
  assign out_next_minute  = minute_r;
  assign out_next_day     = day_r;
  assign out_entries_used = USED_W'(count_r);

  // Fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ALARMS))
    else $error("fill count beyond table size");

  // Insert into a full table is answered at once with a full status
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op_e == OP_INSERT && full)
      |=> (out_valid && out_status == STATUS_FULL && out_entries_used == $past(out_entries_used)))
    else $error("full insert not rejected");

  // Result strobe lasts one cycle and is followed by ready
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result beat longer than one cycle");

  // A wrap-around answer only comes from a non-empty table
  a_day_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_next_day) |-> (out_status == STATUS_OK && out_entries_used != '0))
    else $error("next-day answer without entries");

endmodule

/* tb/tb_sorted_daily_alarm_table_core.sv */
// Self-checking testbench for sorted_daily_alarm_table_core: directed table, then
// fill, drain and mixed runs, checked against typed answers or an in-bench alarm table.
// Depends on sdat_pkg (op and status codes, entry_t) and the core RTL only.
module tb_sorted_daily_alarm_table_core;
  import sdat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = 16;
  localparam int RANDOM_BEATS = 750;
  // Drain wait: the worst item over a full table, plus the busy tail and margin.
  localparam int DRAIN_CYCLES = 3 + 2 * TABLE_DEPTH + 8;

  // One command beat as it goes onto the in_ ports.
  typedef struct {
    op_t         op;
    logic [10:0] alarm_min;
    logic [10:0] start_min;
    logic [15:0] kind;
    logic [31:0] amount;
    logic [3:0]  position;
    logic [10:0] now_min;
  } alarm_cmd_t;

  // One result beat as it comes off the out_ ports.
  typedef struct {
    status_t     status;
    logic [10:0] next_minute;
    logic        next_day;
    logic [4:0]  used;
  } alarm_answer_t;

  // Directed row: command fields, then an answer typed in by hand where it is
  // obvious (status and fill count; next minute and day are zero there).
  typedef struct {
    op_t         op;
    logic [10:0] alarm_min;
    logic [10:0] start_min;
    logic [15:0] kind;
    logic [31:0] amount;
    logic [3:0]  position;
    logic [10:0] now_min;
    bit          typed;
    status_t     status;
    logic [4:0]  used;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 18;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // empty table: query reports empty, delete is out of range
    '{OP_QUERY,  11'd0,    11'd0,    16'h0000, 32'h0000_0000, 4'd0,  11'd5,    1, STATUS_EMPTY, 5'd0},
    '{OP_DELETE, 11'd0,    11'd0,    16'h0000, 32'h0000_0000, 4'd0,  11'd0,    1, STATUS_RANGE, 5'd0},
    // unknown op with every field at all ones changes nothing
    '{OP_NOP,    11'h7FF,  11'h7FF,  16'hFFFF, 32'hFFFF_FFFF, 4'hF,  11'h7FF,  1, STATUS_OK,    5'd0},
    // inserts: last minute of day, minute zero, 11-bit all ones, end minute
    // landing exactly on a day boundary, and a duplicate of 1439
    '{OP_INSERT, 11'd1439, 11'h7FF,  16'hFFFF, 32'hFFFF_FFFF, 4'd0,  11'd0,    1, STATUS_OK,    5'd1},
    '{OP_INSERT, 11'd0,    11'd0,    16'h0000, 32'h0000_0000, 4'hF,  11'h7FF,  1, STATUS_OK,    5'd2},
    '{OP_INSERT, 11'h7FF,  11'h555,  16'hA5A5, 32'h5A5A_A5A5, 4'd0,  11'd0,    1, STATUS_OK,    5'd3},
    '{OP_INSERT, 11'd1320, 11'h2AA,  16'h5A5A, 32'hA5A5_5A5A, 4'd0,  11'd0,    1, STATUS_OK,    5'd4},
    '{OP_INSERT, 11'd1439, 11'd100,  16'h1234, 32'h8000_0001, 4'd0,  11'd0,    1, STATUS_OK,    5'd5},
    // queries: earliest, last minute, beyond every alarm (wraps to the next
    // day), and a now equal to a stored alarm (must pick a strictly later one)
    '{OP_QUERY,  11'd0,    11'd0,    16'h0000, 32'h0000_0000, 4'd0,  11'd0,    0, STATUS_OK,    5'd0},
    '{OP_QUERY,  11'd0,    11'd0,    16'h0000, 32'h0000_0000, 4'd0,  11'd1439, 0, STATUS_OK,    5'd0},
    '{OP_QUERY,  11'd0,    11'd0,    16'h0000, 32'h0000_0000, 4'd0,  11'h7FF,  0, STATUS_OK,    5'd0},
    '{OP_QUERY,  11'd0,    11'd0,    16'h0000, 32'h0000_0000, 4'd0,  11'd1320, 0, STATUS_OK,    5'd0},
    // deletes: top position, last entry, first entry, just past the end
    '{OP_DELETE, 11'd0,    11'd0,    16'h0000, 32'h0000_0000, 4'hF,  11'd0,    1, STATUS_RANGE, 5'd5},
    '{OP_DELETE, 11'd0,    11'd0,    16'h0000, 32'h0000_0000, 4'd4,  11'd0,    1, STATUS_OK,    5'd4},
    '{OP_DELETE, 11'd0,    11'd0,    16'h0000, 32'h0000_0000, 4'd0,  11'd0,    1, STATUS_OK,    5'd3},
    '{OP_QUERY,  11'd0,    11'd0,    16'h0000, 32'h0000_0000, 4'd0,  11'd1438, 0, STATUS_OK,    5'd0},
    '{OP_DELETE, 11'd0,    11'd0,    16'h0000, 32'h0000_0000, 4'd3,  11'd0,    1, STATUS_RANGE, 5'd3},
    // unknown op on a filled table still reports the fill count
    '{OP_NOP,    11'd77,   11'd9,    16'h00FF, 32'h0F0F_0F0F, 4'd2,  11'd300,  1, STATUS_OK,    5'd3}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = OP_NOP;
  logic [10:0] in_alarm_minute = '0;
  logic [10:0] in_start_minute = '0;
  logic [15:0] in_event_kind = '0;
  logic [31:0] in_amount_bits = '0;
  logic [3:0]  in_position = '0;
  logic [10:0] in_now_minute = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [10:0] out_next_minute;
  logic        out_next_day;
  logic [4:0]  out_entries_used;

  // Shadow copy of the alarm table, kept in the same sorted order as the block.
  entry_t        shadow_table [TABLE_DEPTH];
  int unsigned   shadow_fill = 0;
  // Answers owed by the block, oldest first.
  alarm_answer_t pending_answers [$];
  int            beats_sent = 0;
  int            mismatches = 0;

  always #2 clk = ~clk;

  sorted_daily_alarm_table_core #(
    .MAX_ALARMS(TABLE_DEPTH)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_alarm_minute (in_alarm_minute),
    .in_start_minute (in_start_minute),
    .in_event_kind   (in_event_kind),
    .in_amount_bits  (in_amount_bits),
    .in_position     (in_position),
    .in_now_minute   (in_now_minute),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_next_minute (out_next_minute),
    .out_next_day    (out_next_day),
    .out_entries_used(out_entries_used)
  );

  // Apply one accepted command to the shadow table and return the answer the
  // block owes for it.
  function automatic alarm_answer_t apply_alarm_command(input alarm_cmd_t cmd);
    alarm_answer_t answer;
    logic [11:0]   end_sum;
    int unsigned   slot;
    bit            found;
    answer = '{STATUS_OK, 11'd0, 1'b0, 5'd0};
    case (cmd.op)
      OP_INSERT: begin
        if (shadow_fill >= TABLE_DEPTH) begin
          answer.status = STATUS_FULL;
        end else begin
          // New entry goes after every equal or earlier alarm.
          slot = 0;
          while (slot < shadow_fill && shadow_table[slot].alarm <= cmd.alarm_min) slot++;
          for (int k = shadow_fill; k > slot; k--) shadow_table[k] = shadow_table[k-1];
          // Warning window ends two hours on, wrapped once past midnight.
          end_sum = {1'b0, cmd.alarm_min} + 12'(WARN_SPAN);
          if (end_sum > 12'(DAY_MIN)) end_sum = end_sum - 12'(DAY_MIN);
          shadow_table[slot].alarm     = cmd.alarm_min;
          shadow_table[slot].start_min = cmd.start_min;
          shadow_table[slot].end_min   = end_sum[10:0];
          shadow_table[slot].kind      = cmd.kind;
          shadow_table[slot].amount    = cmd.amount;
          shadow_fill++;
        end
      end
      OP_DELETE: begin
        if (cmd.position >= shadow_fill) begin
          answer.status = STATUS_RANGE;
        end else begin
          shadow_fill--;
          for (int k = cmd.position; k < shadow_fill; k++) shadow_table[k] = shadow_table[k+1];
        end
      end
      OP_QUERY: begin
        if (shadow_fill == 0) begin
          answer.status = STATUS_EMPTY;
        end else begin
          found = 1'b0;
          for (int k = 0; k < shadow_fill; k++) begin
            if (!found && shadow_table[k].alarm > cmd.now_min) begin
              answer.next_minute = shadow_table[k].alarm;
              found = 1'b1;
            end
          end
          // Nothing later today: the earliest alarm fires tomorrow.
          if (!found) begin
            answer.next_minute = shadow_table[0].alarm;
            answer.next_day    = 1'b1;
          end
        end
      end
      default: ;
    endcase
    answer.used = 5'(shadow_fill);
    return answer;
  endfunction

  // Minutes are mostly legal, with some past the end of the day, the corner
  // values, and copies of stored alarms to hit equal-minute ordering.
  function automatic logic [10:0] pick_minute();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 13) return 11'($urandom_range(0, 1439));
    if (roll < 15) return 11'($urandom_range(1440, 2047));
    if (roll < 17) begin
      case ($urandom_range(0, 4))
        0:       return 11'd0;
        1:       return 11'd1320;
        2:       return 11'd1321;
        3:       return 11'd1439;
        default: return 11'h7FF;
      endcase
    end
    if (shadow_fill > 0) return shadow_table[$urandom_range(0, shadow_fill - 1)].alarm;
    return 11'($urandom);
  endfunction

  // Every field is random, including those the op ignores.
  function automatic alarm_cmd_t random_cmd(input op_t op);
    alarm_cmd_t cmd;
    cmd.op        = op;
    cmd.alarm_min = pick_minute();
    cmd.start_min = 11'($urandom);
    cmd.kind      = 16'($urandom);
    cmd.amount    = $urandom;
    cmd.position  = 4'($urandom);
    cmd.now_min   = pick_minute();
    if (op == OP_DELETE && shadow_fill > 0 && $urandom_range(0, 9) != 0) begin
      cmd.position = 4'($urandom_range(0, shadow_fill - 1));
    end
    return cmd;
  endfunction

  // Idle gaps are dropped for a stretch in the middle of the run.
  function automatic bit calm_stretch();
    return beats_sent >= 300 && beats_sent < 420;
  endfunction

  // Called at a rising edge where start is not yet assigned. Present the beat,
  // then offer it cycle by cycle, holding start low on random idle cycles,
  // until an edge takes it; then update the shadow table and queue the answer.
  // start is left as it is on return so the next beat can follow back to back.
  task automatic send_cmd(input alarm_cmd_t cmd, input bit typed, input alarm_answer_t typed_answer);
    alarm_answer_t answer;
    bit            offer;
    in_op           <= cmd.op;
    in_alarm_minute <= cmd.alarm_min;
    in_start_minute <= cmd.start_min;
    in_event_kind   <= cmd.kind;
    in_amount_bits  <= cmd.amount;
    in_position     <= cmd.position;
    in_now_minute   <= cmd.now_min;
    do begin
      offer = calm_stretch() || ($urandom_range(0, 99) >= 14);
      start <= offer;
      @(posedge clk);
    end while (!(offer && busy === 1'b0));
    answer = apply_alarm_command(cmd);
    pending_answers.insert(pending_answers.size(), typed ? typed_answer : answer);
    beats_sent++;
  endtask

  task automatic send_checked(input alarm_cmd_t cmd);
    send_cmd(cmd, 1'b0, '{STATUS_OK, 11'd0, 1'b0, 5'd0});
  endtask

  // Fill the table to the top with inserts, a few queries mixed in, then push
  // one or two inserts into the full table and a query.
  task automatic fill_phase();
    while (shadow_fill < TABLE_DEPTH) begin
      send_checked(random_cmd(($urandom_range(0, 9) == 0) ? OP_QUERY : OP_INSERT));
    end
    repeat ($urandom_range(1, 2)) send_checked(random_cmd(OP_INSERT));
    send_checked(random_cmd(OP_QUERY));
  endtask

  // Empty the table with deletes, mostly in range, and a few queries, then poke the empty table.
  task automatic drain_phase();
    while (shadow_fill > 0) begin
      send_checked(random_cmd(($urandom_range(0, 6) == 0) ? OP_QUERY : OP_DELETE));
    end
    send_checked(random_cmd(OP_DELETE));
    send_checked(random_cmd(OP_QUERY));
  endtask

  // Short burst of any ops, queries and inserts weighted up.
  task automatic mixed_phase();
    int unsigned roll;
    repeat (20) begin
      roll = $urandom_range(0, 99);
      if (roll < 35)      send_checked(random_cmd(OP_INSERT));
      else if (roll < 60) send_checked(random_cmd(OP_DELETE));
      else if (roll < 95) send_checked(random_cmd(OP_QUERY));
      else                send_checked(random_cmd(OP_NOP));
    end
  endtask

  // Result checker: every out_valid beat is matched against the oldest answer
  // owed. Sampled at the rising edge, so outputs are seen as they stood in the
  // cycle that edge ends.
  always @(posedge clk) begin
    alarm_answer_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $error("result beat with no command outstanding: status %0d minute %0d",
               out_status, out_next_minute);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (out_status !== want.status) begin
          $error("out_status expected %0d actual %0d", want.status, out_status);
          mismatches++;
        end
        if (out_next_minute !== want.next_minute) begin
          $error("out_next_minute expected %0d actual %0d", want.next_minute, out_next_minute);
          mismatches++;
        end
        if (out_next_day !== want.next_day) begin
          $error("out_next_day expected %0d actual %0d", want.next_day, out_next_day);
          mismatches++;
        end
        if (out_entries_used !== want.used) begin
          $error("out_entries_used expected %0d actual %0d", want.used, out_entries_used);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: reset once, walk the directed table, then random phases.
  initial begin
    alarm_cmd_t    cmd;
    alarm_answer_t hand_answer;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      cmd = '{directed_rows[i].op, directed_rows[i].alarm_min, directed_rows[i].start_min,
              directed_rows[i].kind, directed_rows[i].amount, directed_rows[i].position,
              directed_rows[i].now_min};
      hand_answer = '{directed_rows[i].status, 11'd0, 1'b0, directed_rows[i].used};
      send_cmd(cmd, directed_rows[i].typed, hand_answer);
    end

    while (beats_sent < DIRECTED_ROWS + RANDOM_BEATS) begin
      case ($urandom_range(0, 3))
        0:       fill_phase();
        1:       drain_phase();
        default: mixed_phase();
      endcase
    end
    start <= 1'b0;

    // Drain: wait for every owed answer, then a worst-case item's worth of
    // cycles so a stray extra beat would still be caught.
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 800 beats of one worst-case
  // item each plus idle gaps, well under 0.2 ms).
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sdat_pkg.sv
hw/rtl/sdat_ram.sv
hw/rtl/sorted_daily_alarm_table_core.sv
tb/tb_sorted_daily_alarm_table_core.sv
